/* src/greedy_word_wrap_defines.svh */
// Assertion macros for the greedy word wrap block.
// Expects clk and arst_n in the scope of each use; empty under synthesis.
`ifndef GREEDY_WORD_WRAP_DEFINES_SVH
`define GREEDY_WORD_WRAP_DEFINES_SVH
`ifndef SYNTHESIS
`define WW_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("greedy_word_wrap: same-cycle check failed");
`define WW_ASSERT_NXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("greedy_word_wrap: next-cycle check failed");
`else
`define WW_ASSERT_IMP(label, ante, cons)
`define WW_ASSERT_NXT(label, ante, cons)
`endif
`endif

/* src/wwrap_pkg.sv */
// Shared constants and types of the greedy word wrap block.
// No dependencies; used by wwrap_ctrl and greedy_word_wrap.
`default_nettype none
package wwrap_pkg;

	// Default word buffer depth and line width after reset
	localparam int         WORD_MAX_DEF = 32;
	localparam logic [7:0] LINE_LEN_RST = 8'd70;

	// Character codes
	localparam logic [7:0] CH_SPACE   = 8'h20;
	localparam logic [7:0] CH_TAB     = 8'h09;
	localparam logic [7:0] CH_NEWLINE = 8'h0A;

	// One output byte offered by the sequencer
	typedef struct packed {
		logic       valid;
		logic       last;
		logic [7:0] data;
	} emit_t;

endpackage : wwrap_pkg
`default_nettype wire

/* src/wwrap_word_buf.sv */
// Word buffer: one write port, one registered read port, write-first on a clash.
// Depends on nothing; instantiated by greedy_word_wrap.
`default_nettype none
module wwrap_word_buf #(
	parameter int WORD_MAX = 32,
	parameter int AW       = 5
) (
	input  wire logic          clk,
	input  wire logic          wr_en,
	input  wire logic [AW-1:0] wr_addr,
	input  wire logic [7:0]    wr_data,
	input  wire logic [AW-1:0] rd_addr,
	output logic      [7:0]    rd_data
);

	logic [7:0] mem_q [WORD_MAX];
	logic [7:0] rd_data_q;

	// Write the byte, read the next address with bypass of a same-address write
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (wr_en && (wr_addr == rd_addr)) begin
			rd_data_q <= wr_data;
		end else begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule : wwrap_word_buf
`default_nettype wire

/* src/wwrap_ctrl.sv */
// Sequencer of the word wrap: input decode, line state, fit compare, byte emission.
// Depends on wwrap_pkg; drives the word buffer ports.
`default_nettype none
module wwrap_ctrl #(
	parameter int WORD_MAX = 32,
	parameter int AW       = 5,
	parameter int CW       = 6
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              cfg_we,
	input  wire logic [7:0]        cfg_wdata,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire logic [7:0]        in_ch,
	input  wire logic              in_eoi,
	input  wire logic              adv,
	output wwrap_pkg::emit_t       emit,
	output logic                   wr_en,
	output logic      [AW-1:0]     wr_addr,
	output logic      [7:0]        wr_data,
	output logic      [AW-1:0]     rd_addr,
	input  wire logic [7:0]        rd_data
);
	import wwrap_pkg::*;

	typedef enum logic [6:0] {
		ST_IDLE  = 7'b0000001,
		ST_START = 7'b0000010,
		ST_SEP   = 7'b0000100,
		ST_WORD  = 7'b0001000,
		ST_PARA1 = 7'b0010000,
		ST_PARA2 = 7'b0100000,
		ST_FINAL = 7'b1000000
	} state_t;

	typedef enum logic [1:0] {
		K_CHAR = 2'd0,
		K_GAP  = 2'd1,
		K_NL   = 2'd2,
		K_EOI  = 2'd3
	} kind_t;

	state_t          state_q, state_d, post_state;
	kind_t           kind_q, kind_in;
	logic [CW-1:0]   count_q;
	logic [7:0]      olen_q;
	logic            hw_q;
	logic            hc_q;
	logic [AW-1:0]   idx_q, idx_d;
	logic [7:0]      sep_q;
	logic [7:0]      max_len_q;
	logic            accept;
	logic            fire;
	logic            word_go;
	logic            word_end;
	logic            para_go;
	logic [8:0]      fit_sum;
	logic            fits;

	// Classify the incoming beat
	always_comb begin
		if (in_eoi) begin
			kind_in = K_EOI;
		end else if (in_ch == CH_NEWLINE) begin
			kind_in = K_NL;
		end else if ((in_ch == CH_SPACE) || (in_ch == CH_TAB)) begin
			kind_in = K_GAP;
		end else begin
			kind_in = K_CHAR;
		end
	end

	assign in_ready = (state_q == ST_IDLE);
	assign accept   = in_valid && in_ready;
	assign fire     = emit.valid && adv;

	// Store word characters at the fill position
	assign wr_en   = accept && (kind_in == K_CHAR);
	assign wr_addr = count_q[AW-1:0];
	assign wr_data = in_ch;

	// Word emission and the line fit compare
	assign word_go  = (count_q != '0) &&
	                  ((kind_q != K_CHAR) || (count_q == CW'(WORD_MAX)));
	assign fit_sum  = {1'b0, olen_q} + 9'd1 + 9'(count_q);
	assign fits     = (fit_sum <= {1'b0, max_len_q});
	assign word_end = ((CW'(idx_q) + CW'(1)) == count_q);

	// Pick what follows the word: paragraph break, closing newline or done
	assign para_go = !hw_q && ((kind_q == K_NL) || ((kind_q == K_EOI) && hc_q));
	always_comb begin
		if (para_go) begin
			post_state = ST_PARA1;
		end else if ((kind_q == K_EOI) && (olen_q != 8'd0)) begin
			post_state = ST_FINAL;
		end else begin
			post_state = ST_IDLE;
		end
	end

	// Offer the current byte
	always_comb begin
		emit = '0;
		case (state_q)
			ST_SEP: begin
				emit.valid = 1'b1;
				emit.data  = sep_q;
			end
			ST_WORD: begin
				emit.valid = 1'b1;
				emit.data  = rd_data;
				emit.last  = word_end && (post_state == ST_IDLE);
			end
			ST_PARA1: begin
				emit.valid = 1'b1;
				emit.data  = CH_NEWLINE;
			end
			ST_PARA2, ST_FINAL: begin
				emit.valid = 1'b1;
				emit.last  = 1'b1;
				emit.data  = CH_NEWLINE;
			end
			default: begin
				emit = '0;
			end
		endcase
	end

	// Advance the sequencer
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) state_d = ST_START;
			end
			ST_START: begin
				if (word_go) begin
					state_d = (olen_q == 8'd0) ? ST_WORD : ST_SEP;
				end else begin
					state_d = post_state;
				end
			end
			ST_SEP: begin
				if (fire) state_d = ST_WORD;
			end
			ST_WORD: begin
				if (fire && word_end) state_d = post_state;
			end
			ST_PARA1: begin
				if (fire) state_d = ST_PARA2;
			end
			ST_PARA2, ST_FINAL: begin
				if (fire) state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Step the read index; it rests at zero outside a word
	always_comb begin
		if ((state_q == ST_WORD) && !(fire && word_end)) begin
			idx_d = fire ? (idx_q + AW'(1)) : idx_q;
		end else begin
			idx_d = '0;
		end
	end
	assign rd_addr = idx_d;

	// Control and line state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			kind_q    <= K_CHAR;
			count_q   <= '0;
			olen_q    <= '0;
			hw_q      <= 1'b0;
			hc_q      <= 1'b0;
			idx_q     <= '0;
			max_len_q <= LINE_LEN_RST;
		end else begin
			state_q <= state_d;
			idx_q   <= idx_d;
			if (cfg_we) begin
				max_len_q <= cfg_wdata;
			end
			if (accept) begin
				kind_q <= kind_in;
				if (kind_in == K_CHAR) begin
					count_q <= count_q + CW'(1);
				end
				if ((kind_in == K_CHAR) || (kind_in == K_GAP)) begin
					hc_q <= 1'b1;
				end
			end
			if ((state_q == ST_START) && word_go) begin
				hw_q <= 1'b1;
				if ((olen_q == 8'd0) || !fits) begin
					olen_q <= 8'(count_q);
				end else begin
					olen_q <= fit_sum[7:0];
				end
			end
			if ((state_q == ST_WORD) && fire && word_end) begin
				count_q <= '0;
			end
			if ((state_q == ST_PARA2) && fire) begin
				olen_q <= '0;
			end
			// Close the input line or the whole text on the way back to idle
			if ((state_q != ST_IDLE) && (state_d == ST_IDLE)) begin
				if ((kind_q == K_NL) || (kind_q == K_EOI)) begin
					hw_q <= 1'b0;
					hc_q <= 1'b0;
				end
				if (kind_q == K_EOI) begin
					olen_q  <= '0;
					count_q <= '0;
				end
			end
		end
	end

	// Separator chosen by the fit compare
	always_ff @(posedge clk) begin
		if ((state_q == ST_START) && word_go) begin
			sep_q <= fits ? CH_SPACE : CH_NEWLINE;
		end
	end

endmodule : wwrap_ctrl
`default_nettype wire

/* src/greedy_word_wrap.sv */
// Greedy word wrap: an item is taken in one cycle and decoded in the next; then the
// emission sequencer offers its result bytes in turn, each held until the output
// register takes it. Word bytes come one per cycle, while the output is not stalled,
// from the single read port of the word buffer.
// Reset clears the sequencer and line state and sets max_line_len to 70; the
// word buffer is not cleared, only bytes written for the current word are read.
`default_nettype none
`include "greedy_word_wrap_defines.svh"
module greedy_word_wrap #(
	parameter int WORD_MAX = wwrap_pkg::WORD_MAX_DEF
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       cfg_we,
	input  wire logic [7:0] cfg_wdata,  // max_line_len
	input  wire logic       s_tvalid,
	output logic            s_tready,
	input  wire logic [7:0] s_tdata,    // [7:0] ch
	input  wire logic       s_tuser,    // [0] end_of_input
	output logic            m_tvalid,
	input  wire logic       m_tready,
	output logic      [7:0] m_tdata,    // [7:0] out_char
	output logic            m_tlast     // last_in_run
);
	import wwrap_pkg::*;

	localparam int AW = (WORD_MAX > 1) ? $clog2(WORD_MAX) : 1;
	localparam int CW = $clog2(WORD_MAX + 1);

	emit_t           emit;
	logic            adv;
	logic            wr_en;
	logic [AW-1:0]   wr_addr;
	logic [7:0]      wr_data;
	logic [AW-1:0]   rd_addr;
	logic [7:0]      rd_data;
	logic            out_valid_q;
	logic [7:0]      out_data_q;
	logic            out_last_q;

	wwrap_word_buf #(
		.WORD_MAX (WORD_MAX),
		.AW       (AW)
	) u_word_buf (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	wwrap_ctrl #(
		.WORD_MAX (WORD_MAX),
		.AW       (AW),
		.CW       (CW)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_ch     (s_tdata),
		.in_eoi    (s_tuser),
		.adv       (adv),
		.emit      (emit),
		.wr_en     (wr_en),
		.wr_addr   (wr_addr),
		.wr_data   (wr_data),
		.rd_addr   (rd_addr),
		.rd_data   (rd_data)
	);

	// Output register: load a new beat whenever the old one is gone or taken
	assign adv = !out_valid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= emit.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && emit.valid) begin
			out_data_q <= emit.data;
			out_last_q <= emit.last;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;
	assign m_tlast  = out_last_q;

	// An accepted beat is decoded before the next one is taken
	`WW_ASSERT_NXT(a_busy_after_accept, s_tvalid && s_tready, !s_tready)
	// No byte is offered while waiting for input
	`WW_ASSERT_IMP(a_idle_no_emit, s_tready, !emit.valid)
	// A byte held back by a full output register stays put
	`WW_ASSERT_NXT(a_emit_hold, emit.valid && !adv, $stable(emit))

endmodule : greedy_word_wrap
`default_nettype wire
